### src/pfdrc_pkg.sv
// Shared definitions for the packet FIFO with duplicate rejection and range count.
// Holds field widths, command codes, controller states and control/status structs.
// No dependencies.
package pfdrc_pkg;

    // default queue depth and fixed field widths
    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int CAP_W           = 9;
    localparam int CNT_W           = 9;
    localparam int SRC_W           = 16;
    localparam int DST_W           = 16;
    localparam int TS_W            = 32;
    localparam int WORD_W          = SRC_W + DST_W + TS_W;
    localparam int CMD_W           = 2;
    localparam int S_DATA_W        = SRC_W + DST_W + 3 * TS_W;
    localparam int M_DATA_W        = 80;
    localparam int M_USER_W        = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // command codes; the fourth code is unused and yields an all-zero result
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FWD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CNT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_POP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input transfer, start a new item
        logic scan_rd;  // issue one scan read
        logic pop_rd;   // read the head entry
        logic commit;   // update queue state and load the result register
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic scan_done; // no scan reads left
        logic occ_nz;    // queue holds at least one packet
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

### src/pfdrc_ctrl.sv
// Controller state machine: sequences capture, scan, pop and commit of one item.
// Depends on pfdrc_pkg.
module pfdrc_ctrl
    import pfdrc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_cmd,
    input  t_status          i_status,
    output logic             o_in_ready,
    output t_ctrl            o_ctrl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_ADD, CMD_CNT: n_state = S_SCAN;
                        CMD_FWD:          n_state = i_status.occ_nz ? S_POP : S_DONE;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_POP:   n_state = S_DONE;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_ctrl.load    = (r_state == S_IDLE) && i_in_valid;
        o_ctrl.scan_rd = (r_state == S_SCAN) && !i_status.scan_done;
        o_ctrl.pop_rd  = (r_state == S_POP);
        o_ctrl.commit  = (r_state == S_DONE) && i_status.out_free;
    end

endmodule

### src/pfdrc_datapath.sv
// Datapath: packet store memory, queue pointers, scan compare, result register.
// Depends on pfdrc_pkg; driven by pfdrc_ctrl commands.
module pfdrc_datapath
    import pfdrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic [CMD_W-1:0]    i_in_cmd,
    input  logic [S_DATA_W-1:0] i_in_data,
    input  logic                i_out_ready,
    input  t_ctrl               i_ctrl,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic [M_DATA_W-1:0] o_out_data,
    output logic [M_USER_W-1:0] o_out_user
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = (OW > CAP_W) ? OW : CAP_W;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [WORD_W-1:0] r_mem [QUEUE_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_valid;

    logic [CAP_W-1:0]  r_cap;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [OW-1:0]     r_occ;
    logic [AW-1:0]     r_scan_ptr;
    logic [OW-1:0]     r_scan_left;
    logic              r_dup;
    logic [CNT_W-1:0]  r_cnt;

    logic [CMD_W-1:0]  r_cmd;
    logic [SRC_W-1:0]  r_src;
    logic [DST_W-1:0]  r_dst;
    logic [TS_W-1:0]   r_ts;
    logic [TS_W-1:0]   r_lo;
    logic [TS_W-1:0]   r_hi;

    logic              r_out_valid;
    logic              r_out_acc;
    logic              r_out_pv;
    logic [SRC_W-1:0]  r_out_src;
    logic [DST_W-1:0]  r_out_dst;
    logic [TS_W-1:0]   r_out_ts;
    logic [CNT_W-1:0]  r_out_cnt;

    logic [WORD_W-1:0] new_word;
    logic [AW-1:0]     rd_addr;
    logic              rd_en;
    logic              hit_dup;
    logic              hit_cnt;
    logic [CAP_W-1:0]  cap_eff;
    logic              at_limit;
    logic              do_add;
    logic              do_pop;
    logic              out_free;

    assign new_word = {r_src, r_dst, r_ts};
    assign rd_addr  = i_ctrl.pop_rd ? r_head : r_scan_ptr;
    assign rd_en    = i_ctrl.pop_rd || i_ctrl.scan_rd;
    assign out_free = !r_out_valid || i_out_ready;

    // compare of the entry read in the previous cycle
    assign hit_dup = (r_rd_data == new_word);
    assign hit_cnt = (r_rd_data[TS_W +: DST_W] == r_dst)
                   && (r_rd_data[TS_W-1:0] >= r_lo)
                   && (r_rd_data[TS_W-1:0] <= r_hi);

    // eviction limit: zero acts as one, limited to the queue depth
    assign cap_eff  = (r_cap == '0) ? CAP_W'(1) : r_cap;
    assign at_limit = (LW'(r_occ) >= LW'(cap_eff)) || (r_occ == OW'(QUEUE_DEPTH));

    assign do_add = i_ctrl.commit && (r_cmd == CMD_ADD) && !r_dup;
    assign do_pop = i_ctrl.commit && (r_cmd == CMD_FWD) && (r_occ != '0);

    // packet store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            r_mem[r_tail] <= new_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_in_cmd;
            r_src <= i_in_data[0 +: SRC_W];
            r_dst <= i_in_data[SRC_W +: DST_W];
            r_ts  <= i_in_data[SRC_W + DST_W +: TS_W];
            r_lo  <= i_in_data[SRC_W + DST_W + TS_W +: TS_W];
            r_hi  <= i_in_data[SRC_W + DST_W + 2 * TS_W +: TS_W];
        end
    end

    // scan pointer, remaining count and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_scan_left <= '0;
            r_scan_ptr  <= '0;
            r_dup       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_rd_valid <= i_ctrl.scan_rd;
            if (i_ctrl.load) begin
                r_scan_ptr  <= r_head;
                r_scan_left <= r_occ;
                r_dup       <= 1'b0;
                r_cnt       <= '0;
            end else begin
                if (i_ctrl.scan_rd) begin
                    r_scan_ptr  <= next_slot(r_scan_ptr);
                    r_scan_left <= r_scan_left - 1'b1;
                end
                if (r_rd_valid) begin
                    r_dup <= r_dup || hit_dup;
                    r_cnt <= r_cnt + CNT_W'(hit_cnt);
                end
            end
        end
    end

    // queue pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else if (do_add) begin
            r_tail <= next_slot(r_tail);
            if (at_limit && (r_occ != '0)) begin
                r_head <= next_slot(r_head);
            end else begin
                r_occ <= r_occ + 1'b1;
            end
        end else if (do_pop) begin
            r_head <= next_slot(r_head);
            r_occ  <= r_occ - 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_out_acc <= do_add;
            r_out_pv  <= do_pop;
            r_out_src <= do_pop ? r_rd_data[TS_W + DST_W +: SRC_W] : '0;
            r_out_dst <= do_pop ? r_rd_data[TS_W +: DST_W] : '0;
            r_out_ts  <= do_pop ? r_rd_data[TS_W-1:0] : '0;
            r_out_cnt <= (r_cmd == CMD_CNT) ? r_cnt : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {(M_DATA_W - SRC_W - DST_W - TS_W - CNT_W)'(0),
                          r_out_cnt, r_out_ts, r_out_dst, r_out_src};
    assign o_out_user  = {r_out_pv, r_out_acc};

    assign o_status.scan_done = (r_scan_left == '0);
    assign o_status.occ_nz    = (r_occ != '0);
    assign o_status.out_free  = out_free;

    // checks
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan_rd |-> (r_scan_left != '0) && (r_scan_left <= r_occ))
        else $error("scan read beyond stored entries");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.pop_rd |-> (r_occ != '0))
        else $error("head read on empty queue");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_add |=> (r_occ != '0))
        else $error("queue empty after accepted add");

endmodule

### src/packet_fifo_dedup_range_count.sv
// Sequence: an add or count input transfer is followed by a scan of all stored entries
// (one stored entry read per cycle on the single memory read port), a drain state and the
// result load, which a waiting result stalls; a forward on a non-empty queue reads the head
// entry first; a forward on an empty queue or an unused code goes to the result load.
// One item at a time: the next input transfer is taken in the cycle after the result load.
// Reset (synchronous, active low) empties the queue and sets capacity to 256; store not cleared.
module packet_fifo_dedup_range_count
    import pfdrc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: capacity limit
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata: pkt_source, pkt_destination, pkt_timestamp, range_start, range_end
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // tuser: command
    input  logic [CMD_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata: out_source, out_destination, out_timestamp, match_count, zero pad
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // tuser: accepted, packet_valid
    output logic [M_USER_W-1:0] o_m_axis_tuser
);

    t_ctrl   ctrl;
    t_status status;

    pfdrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tuser),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_ctrl     (ctrl)
    );

    pfdrc_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule
